[design/weighted_cluster_moments_top_assert.svh]
// ----------------------------------------------------------------------------
// weighted cluster moments assertion macros
// concurrent checks on the rising edge of clk, masked while rst is high
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_CLUSTER_MOMENTS_TOP_ASSERT_SVH
`define WEIGHTED_CLUSTER_MOMENTS_TOP_ASSERT_SVH

// same-cycle implication
`define WCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wcm check failed");

// next-cycle implication
`define WCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wcm check failed");

`endif

[design/wcm_pkg.sv]
// ----------------------------------------------------------------------------
// wcm_pkg
// field widths, moment indexes, status codes and controller command types
// ----------------------------------------------------------------------------
package wcm_pkg;

  localparam int CHARGE_W = 12;
  localparam int COORD_W  = 12;
  localparam int MEAN1_W  = 20;
  localparam int MEAN2_W  = 31;
  localparam int MEANX_W  = 32;
  localparam int OUT_W    = 32;
  localparam int TOTAL_W  = 20;
  localparam int HITS_W   = 8;
  localparam int STATUS_W = 2;
  localparam int NUM_MOM  = 9;
  localparam int IDX_W    = 4;

  localparam logic [IDX_W-1:0] MOM_X  = 4'd0;
  localparam logic [IDX_W-1:0] MOM_Y  = 4'd1;
  localparam logic [IDX_W-1:0] MOM_Z  = 4'd2;
  localparam logic [IDX_W-1:0] MOM_XX = 4'd3;
  localparam logic [IDX_W-1:0] MOM_YY = 4'd4;
  localparam logic [IDX_W-1:0] MOM_ZZ = 4'd5;
  localparam logic [IDX_W-1:0] MOM_XY = 4'd6;
  localparam logic [IDX_W-1:0] MOM_YZ = 4'd7;
  localparam logic [IDX_W-1:0] MOM_ZX = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP = 2'd2;

  typedef struct packed {
    logic             capture;
    logic             check;
    logic             mul;
    logic             acc;
    logic             div_load;
    logic             div_step;
    logic             div_store;
    logic             publish;
    logic [IDX_W-1:0] idx;
  } wcm_cmd_t;

  typedef struct packed {
    logic full;
    logic out_busy;
  } wcm_stat_t;

endpackage

[design/wcm_hit_if.sv]
// ----------------------------------------------------------------------------
// wcm_hit_if
// hit channel: valid/ready handshake with start flag, charge and position
// ----------------------------------------------------------------------------
interface wcm_hit_if
  import wcm_pkg::*;
();

  logic                       valid;
  logic                       ready;
  logic                       start_cluster;
  logic        [CHARGE_W-1:0] charge;
  logic signed [COORD_W-1:0]  pos_x;
  logic signed [COORD_W-1:0]  pos_y;
  logic signed [COORD_W-1:0]  pos_z;

  modport source (
    output valid, start_cluster, charge, pos_x, pos_y, pos_z,
    input  ready
  );

  modport sink (
    input  valid, start_cluster, charge, pos_x, pos_y, pos_z,
    output ready
  );

endinterface

[design/wcm_result_if.sv]
// ----------------------------------------------------------------------------
// wcm_result_if
// result channel: valid/ready handshake with means, totals and status
// ----------------------------------------------------------------------------
interface wcm_result_if
  import wcm_pkg::*;
();

  logic                       valid;
  logic                       ready;
  logic signed [MEAN1_W-1:0]  mean_x;
  logic signed [MEAN1_W-1:0]  mean_y;
  logic signed [MEAN1_W-1:0]  mean_z;
  logic        [MEAN2_W-1:0]  mean_xx;
  logic        [MEAN2_W-1:0]  mean_yy;
  logic        [MEAN2_W-1:0]  mean_zz;
  logic signed [MEANX_W-1:0]  mean_xy;
  logic signed [MEANX_W-1:0]  mean_yz;
  logic signed [MEANX_W-1:0]  mean_zx;
  logic        [TOTAL_W-1:0]  total_charge;
  logic        [HITS_W-1:0]   hits_in_cluster;
  logic        [STATUS_W-1:0] status;

  modport source (
    output valid, mean_x, mean_y, mean_z, mean_xx, mean_yy, mean_zz,
           mean_xy, mean_yz, mean_zx, total_charge, hits_in_cluster, status,
    input  ready
  );

  modport sink (
    input  valid, mean_x, mean_y, mean_z, mean_xx, mean_yy, mean_zz,
           mean_xy, mean_yz, mean_zx, total_charge, hits_in_cluster, status,
    output ready
  );

endinterface

[design/wcm_ctrl.sv]
// ----------------------------------------------------------------------------
// wcm_ctrl
// sequencer: capture, multiply-accumulate of nine moments, nine serial divides
// ----------------------------------------------------------------------------
module wcm_ctrl
  import wcm_pkg::*;
#(
  parameter int FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  wcm_stat_t stat,
  output wcm_cmd_t  cmd
);

  localparam int Q_W    = 2 * COORD_W - 1 + FRAC_BITS;
  localparam int ITER_W = $clog2(Q_W);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_ACC    = 8'b0000_1000,
    S_DLOAD  = 8'b0001_0000,
    S_DITER  = 8'b0010_0000,
    S_DSTORE = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [ITER_W-1:0]   iter, iter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= MOM_X;
      iter  <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    iter_next  = iter;
    cmd        = '0;
    cmd.idx    = idx;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        idx_next   = MOM_X;
        state_next = stat.full ? S_DLOAD : S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (idx == MOM_ZX) begin
          idx_next   = MOM_X;
          state_next = S_DLOAD;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_MUL;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        iter_next    = '0;
        state_next   = S_DITER;
      end
      S_DITER: begin
        cmd.div_step = 1'b1;
        iter_next    = iter + 1'b1;
        if (iter == ITER_W'(Q_W - 1)) begin
          state_next = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        if (idx == MOM_ZX) begin
          idx_next   = MOM_X;
          state_next = S_OUT;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_DLOAD;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/wcm_dp.sv]
// ----------------------------------------------------------------------------
// wcm_dp
// datapath: moment sums, shared multiplier, restoring divider, result register
// ----------------------------------------------------------------------------
module wcm_dp
  import wcm_pkg::*;
#(
  parameter int MAX_HITS  = 255,
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start_cluster,
  input  logic        [CHARGE_W-1:0] charge,
  input  logic signed [COORD_W-1:0]  pos_x,
  input  logic signed [COORD_W-1:0]  pos_y,
  input  logic signed [COORD_W-1:0]  pos_z,
  input  wcm_cmd_t                   cmd,
  output wcm_stat_t                  stat,
  wcm_result_if.source               result
);

  localparam int HIT_W  = $clog2(MAX_HITS + 1);
  localparam int WSUM_W = CHARGE_W + HIT_W;
  localparam int SUM_W  = CHARGE_W + 2 * COORD_W + HIT_W;
  localparam int P1_W   = CHARGE_W + COORD_W;
  localparam int PROD_W = P1_W + COORD_W;
  localparam int SQ_W   = 2 * COORD_W - 1;
  localparam int Q_W    = SQ_W + FRAC_BITS;
  localparam int R_W    = (Q_W + 1 > OUT_W) ? Q_W + 1 : OUT_W;

  // captured hit
  logic        [CHARGE_W-1:0] w;
  logic signed [COORD_W-1:0]  x, y, z;

  // cluster state
  logic        [WSUM_W-1:0]   weight;
  logic        [HIT_W-1:0]    count;
  logic signed [SUM_W-1:0]    sums [NUM_MOM];
  logic signed [P1_W-1:0]     wp [3];
  logic                       dropped;

  // multiplier
  logic signed [P1_W-1:0]     wext;
  logic signed [P1_W-1:0]     opa;
  logic signed [COORD_W-1:0]  opb;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [PROD_W-1:0]   prod;

  // divider
  logic signed [SUM_W-1:0]    sel_sum;
  logic        [SUM_W-1:0]    mag;
  logic                       neg;
  logic        [WSUM_W-1:0]   rem;
  logic        [Q_W-1:0]      dq;
  logic        [Q_W-1:0]      quo;
  logic        [WSUM_W:0]     trial;
  logic                       ge;
  logic signed [Q_W:0]        qs;
  logic signed [R_W-1:0]      res;
  logic        [OUT_W-1:0]    means [NUM_MOM];

  // result register
  logic                       out_valid;
  logic        [OUT_W-1:0]    out_means [NUM_MOM];
  logic        [TOTAL_W-1:0]  out_total;
  logic        [HITS_W-1:0]   out_hits;
  logic        [STATUS_W-1:0] out_status;

  logic                       full;
  logic                       wzero;

  assign full  = (count >= HIT_W'(MAX_HITS));
  assign wzero = (weight == '0);

  assign stat.full     = full;
  assign stat.out_busy = out_valid && !result.ready;

  // operand select for the nine products
  assign wext = signed'({{COORD_W{1'b0}}, w});

  always_comb begin
    opa = wext;
    opb = x;
    case (cmd.idx)
      MOM_X:   begin opa = wext;  opb = x; end
      MOM_Y:   begin opa = wext;  opb = y; end
      MOM_Z:   begin opa = wext;  opb = z; end
      MOM_XX:  begin opa = wp[0]; opb = x; end
      MOM_YY:  begin opa = wp[1]; opb = y; end
      MOM_ZZ:  begin opa = wp[2]; opb = z; end
      MOM_XY:  begin opa = wp[0]; opb = y; end
      MOM_YZ:  begin opa = wp[1]; opb = z; end
      MOM_ZX:  begin opa = wp[2]; opb = x; end
      default: begin opa = wext;  opb = x; end
    endcase
  end

  assign prod_next = opa * opb;

  // sign and magnitude of the selected sum
  assign sel_sum = sums[cmd.idx];
  assign mag     = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);

  // one quotient bit per step
  assign trial = {rem, dq[Q_W-1]};
  assign ge    = (trial >= {1'b0, weight});
  assign qs    = neg ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
  assign res   = R_W'(qs);

  always_ff @(posedge clk) begin
    if (rst) begin
      weight  <= '0;
      count   <= '0;
      dropped <= 1'b0;
      for (int i = 0; i < NUM_MOM; i++) begin
        sums[i] <= '0;
      end
    end else begin
      if (cmd.capture && start_cluster) begin
        weight <= '0;
        count  <= '0;
        for (int i = 0; i < NUM_MOM; i++) begin
          sums[i] <= '0;
        end
      end
      if (cmd.check) begin
        dropped <= full;
        if (!full) begin
          weight <= weight + WSUM_W'(w);
          count  <= count + 1'b1;
        end
      end
      if (cmd.acc) begin
        sums[cmd.idx] <= sums[cmd.idx] + SUM_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      w <= charge;
      x <= pos_x;
      y <= pos_y;
      z <= pos_z;
    end
    if (cmd.mul) begin
      prod <= prod_next;
    end
    if (cmd.acc && (cmd.idx <= MOM_Z)) begin
      wp[cmd.idx[1:0]] <= P1_W'(prod);
    end
    if (cmd.div_load) begin
      neg <= sel_sum[SUM_W-1];
      rem <= WSUM_W'(mag >> SQ_W);
      dq  <= Q_W'(mag[SQ_W-1:0]) << FRAC_BITS;
      quo <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? WSUM_W'(trial - {1'b0, weight}) : WSUM_W'(trial);
      dq  <= dq << 1;
      quo <= {quo[Q_W-2:0], ge};
    end
    if (cmd.div_store) begin
      means[cmd.idx] <= wzero ? '0 : res[OUT_W-1:0];
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      for (int i = 0; i < NUM_MOM; i++) begin
        out_means[i] <= means[i];
      end
      out_total  <= TOTAL_W'(weight);
      out_hits   <= HITS_W'(count);
      out_status <= dropped ? ST_DROP : (wzero ? ST_ZERO : ST_OK);
    end
  end

  assign result.valid           = out_valid;
  assign result.mean_x          = out_means[MOM_X][MEAN1_W-1:0];
  assign result.mean_y          = out_means[MOM_Y][MEAN1_W-1:0];
  assign result.mean_z          = out_means[MOM_Z][MEAN1_W-1:0];
  assign result.mean_xx         = out_means[MOM_XX][MEAN2_W-1:0];
  assign result.mean_yy         = out_means[MOM_YY][MEAN2_W-1:0];
  assign result.mean_zz         = out_means[MOM_ZZ][MEAN2_W-1:0];
  assign result.mean_xy         = out_means[MOM_XY][MEANX_W-1:0];
  assign result.mean_yz         = out_means[MOM_YZ][MEANX_W-1:0];
  assign result.mean_zx         = out_means[MOM_ZX][MEANX_W-1:0];
  assign result.total_charge    = out_total;
  assign result.hits_in_cluster = out_hits;
  assign result.status          = out_status;

endmodule

[design/weighted_cluster_moments_top.sv]
// ----------------------------------------------------------------------------
// weighted_cluster_moments_top
// charge-weighted centroid and second moments of a cluster of detector hits
//
//   channel  dir  word
//   hit      in   start_cluster, charge, pos_x, pos_y, pos_z
//   result   out  nine means, total_charge, hits_in_cluster, status
//
// the bit-serial divider forms the nine means one after another, and a new hit
// is taken only once the sequencer is back in idle
// a dropped hit skips the multiply-accumulate steps
// a new hit is taken while the last result word waits on result.ready
// reset clears the cluster sums, the sequencer and the result valid
// ----------------------------------------------------------------------------
`include "weighted_cluster_moments_top_assert.svh"

module weighted_cluster_moments_top
  import wcm_pkg::*;
#(
  parameter int MAX_HITS  = 255,
  parameter int FRAC_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  wcm_hit_if.sink       hit,
  wcm_result_if.source  result
);

  wcm_cmd_t  cmd;
  wcm_stat_t stat;
  logic      in_ready;

  assign hit.ready = in_ready;

  wcm_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (hit.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wcm_dp #(
    .MAX_HITS  (MAX_HITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .start_cluster (hit.start_cluster),
    .charge        (hit.charge),
    .pos_x         (hit.pos_x),
    .pos_y         (hit.pos_y),
    .pos_z         (hit.pos_z),
    .cmd           (cmd),
    .stat          (stat),
    .result        (result)
  );

  // checks
  `WCM_ASSERT_IMP(a_take_starts_capture, hit.valid && hit.ready, cmd.capture)
  `WCM_ASSERT_NEXT(a_no_early_publish, hit.valid && hit.ready, !cmd.publish)
  `WCM_ASSERT_IMP(a_publish_when_free, cmd.publish, !(result.valid && !result.ready))
  `WCM_ASSERT_IMP(a_drop_only_full, result.valid && (result.status == ST_DROP), result.hits_in_cluster == HITS_W'(MAX_HITS))

endmodule
